// ----- rtl/shs_pkg.sv -----
// shs_pkg: shared types, constants and functions of the sha-256 stream hasher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package shs_pkg;

   localparam int unsigned FifoDepth = 4;
   localparam int unsigned FifoAw    = 2;
   localparam int unsigned CountW    = 61;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        digest_last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } eng_state_type;

   function automatic logic [31:0] init_h(input logic [2:0] i);
      logic [31:0] r;
      begin
         case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
         endcase
         return r;
      end
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] r;
      begin
         case (t)
            6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
            6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
            6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
            6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
            6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
         endcase
         return r;
      end
   endfunction

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

// ----- rtl/shs_fifo.sv -----
// shs_fifo: short request queue between the front end and the hashing engine
// depends on shs_pkg
`timescale 1ns / 1ps
`default_nettype none
module shs_fifo import shs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output req_type      out_data
);

   req_type              mem_ff [FifoDepth];
   logic [FifoAw-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [FifoAw:0]      cnt_ff, cnt_in;
   logic                 push, pop;

   // handshake
   assign in_ready  = (cnt_ff != (FifoAw+1)'(FifoDepth));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer update
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (FifoAw+1)'(push) - (FifoAw+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/shs_engine.sv -----
// shs_engine: byte packing, padding, 64-round compression and digest output
// depends on shs_pkg
`timescale 1ns / 1ps
`default_nettype none
module shs_engine import shs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   eng_state_type      st_ff, st_in;
   logic [31:0]        h_ff [8];
   logic [31:0]        v_ff [8];
   logic [31:0]        w_ff [16];
   logic [CountW-1:0]  cnt_ff;
   logic [5:0]         rnd_ff;
   logic [2:0]         ow_ff;
   logic               pend_ff;   // padding still to do after this block
   logic               final_ff;  // this block is the last one
   logic [2:0]         pst_ff;    // pad phase: 0 none,1 pad1,2 zero block

   logic               take;
   logic [5:0]         pos;
   logic [31:0]        wt, w15, w2, s0, s1, wnew, t1, t2;
   logic [31:0]        a, e;
   logic [63:0]        bits;

   assign take     = in_valid && in_ready;
   assign pos      = cnt_ff[5:0];
   assign bits     = {cnt_ff, 3'b000};
   assign out_valid = (st_ff == ST_EMIT);
   assign out_data = '{digest_word: h_ff[ow_ff], digest_last: (ow_ff == 3'd7)};
   assign in_ready = (st_ff == ST_IDLE);

   // message schedule and round function
   always_comb begin
      w15  = w_ff[4'(rnd_ff - 6'd15)];
      w2   = w_ff[4'(rnd_ff - 6'd2)];
      s0   = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
      s1   = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
      wnew = w_ff[rnd_ff[3:0]] + s0 + w_ff[4'(rnd_ff - 6'd7)] + s1;
      wt   = (rnd_ff < 6'd16) ? w_ff[rnd_ff[3:0]] : wnew;
      a    = v_ff[0];
      e    = v_ff[4];
      t1   = v_ff[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
           + ((e & v_ff[5]) ^ (~e & v_ff[6])) + round_k(rnd_ff) + wt;
      t2   = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
           + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (take) begin
               if (in_data.byte_present && pos == 6'd63) st_in = ST_ROUND;
               else if (in_data.message_end) st_in = ST_PAD;
            end
         end
         ST_ROUND: if (rnd_ff == 6'd63) st_in = ST_FOLD;
         ST_FOLD: begin
            if (final_ff) st_in = ST_EMIT;
            else if (pend_ff) st_in = ST_PAD;
            else st_in = ST_IDLE;
         end
         ST_PAD: st_in = ST_ROUND;
         ST_EMIT: if (out_ready && ow_ff == 3'd7) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= init_h(3'(i));
         for (int i = 0; i < 8; i++) v_ff[i] <= '0;
         cnt_ff   <= '0;
         rnd_ff   <= '0;
         ow_ff    <= '0;
         pend_ff  <= 1'b0;
         final_ff <= 1'b0;
         pst_ff   <= '0;
      end else begin
         case (st_ff)
            ST_IDLE: begin
               if (take) begin
                  if (in_data.byte_present) begin
                     if (pos[1:0] == 2'd0)
                        w_ff[pos[5:2]] <= {in_data.data_byte, 24'h0};
                     else
                        w_ff[pos[5:2]] <= w_ff[pos[5:2]]
                           | ({24'h0, in_data.data_byte} << ((5'd3 - 5'(pos[1:0])) * 5'd8));
                     cnt_ff <= cnt_ff + 1'b1;
                  end
                  pend_ff  <= in_data.message_end;
                  final_ff <= 1'b0;
                  pst_ff   <= 3'd1;
                  for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
               end
            end
            ST_PAD: begin
               // pad byte at pos, zero fill, length if room
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
               if (pst_ff == 3'd1) begin
                  for (int j = 0; j < 16; j++) begin
                     if (4'(j) == pos[5:2]) begin
                        if (pos[1:0] == 2'd0)
                           w_ff[j] <= 32'h80000000;
                        else
                           w_ff[j] <= w_ff[j]
                              | (32'h80 << ((5'd3 - 5'(pos[1:0])) * 5'd8));
                     end else if (pos < 6'd56 && j == 14) begin
                        w_ff[j] <= bits[63:32];
                     end else if (pos < 6'd56 && j == 15) begin
                        w_ff[j] <= bits[31:0];
                     end else if (6'(4*j) > pos) begin
                        w_ff[j] <= '0;
                     end
                  end
                  if (pos < 6'd56) begin
                     pend_ff  <= 1'b0;
                     final_ff <= 1'b1;
                  end else begin
                     pend_ff <= 1'b1;
                     pst_ff  <= 3'd2;
                  end
               end else begin
                  for (int j = 0; j < 14; j++) w_ff[j] <= '0;
                  w_ff[14] <= bits[63:32];
                  w_ff[15] <= bits[31:0];
                  pend_ff  <= 1'b0;
                  final_ff <= 1'b1;
               end
            end
            ST_ROUND: begin
               if (rnd_ff >= 6'd16) w_ff[rnd_ff[3:0]] <= wnew;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               rnd_ff  <= rnd_ff + 1'b1;
            end
            ST_FOLD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               ow_ff <= '0;
            end
            ST_EMIT: begin
               if (out_ready) begin
                  ow_ff <= ow_ff + 1'b1;
                  if (ow_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) h_ff[i] <= init_h(3'(i));
                     cnt_ff   <= '0;
                     final_ff <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sha256_stream_hasher_unit.sv -----
// sha256_stream_hasher_unit: top level of the sha-256 stream hasher
// depends on shs_pkg, shs_fifo, shs_engine
//
// usage: one message byte per req beat (req_valid/req_ready), with
// byte_present and message_end flags; an end beat without a byte ends
// the message as is, so an empty message works.
// a 4-entry queue takes beats while the engine is busy; each beat is
// registered in the queue before the engine sees it.
// the engine takes one beat per cycle when idle; a beat that fills the
// 64-byte block starts a compression (take, 64 rounds, fold).
// an end beat adds one compression, or two when the padding spills into
// a second block (pad set-up, 64 rounds, fold each), then the eight
// digest words go out on rsp, word 0 first, digest_last on the eighth;
// one word per cycle while rsp_ready is high.
// the single round unit sets the sustained rate: the engine takes no
// beats while it compresses a block.
// a stalled receiver holds the engine in the digest phase; the queue keeps
// accepting until full.
// reset (synchronous, active high) clears the queue, loads the initial
// hash values and zeroes the byte count.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher_unit import shs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    q_valid, q_ready;
   req_type q_data;

   // front queue
   shs_fifo u_fifo (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_data(req_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   // hashing engine
   shs_engine u_eng (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(rsp_data)
   );

   // no digest word while the engine is taking a beat
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && q_ready)) else $error("digest and intake overlap");

   // a last word finishes the digest
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.digest_last |=> !rsp_valid)
      else $error("digest runs past last word");

endmodule
`default_nettype wire
